FILE: design/integer_deque_list_engine_defines.svh
// Assertion macros shared by the deque engine files.
`ifndef INTEGER_DEQUE_LIST_ENGINE_DEFINES_SVH
`define INTEGER_DEQUE_LIST_ENGINE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define IDQE_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("deque engine check failed");

// The condition must hold in the cycle after the trigger.
`define IDQE_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("deque engine check failed");

`endif

FILE: design/idqe_pkg.sv
// Types, codes and default sizes of the deque engine.
package idqe_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int KIND_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int CNT_W    = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH_BACK    = 4'd0,
		K_PUSH_FRONT   = 4'd1,
		K_POP_BACK     = 4'd2,
		K_POP_FRONT    = 4'd3,
		K_REMOVE_AT    = 4'd4,
		K_REMOVE_VALUE = 4'd5,
		K_READ_FRONT   = 4'd6,
		K_READ_BACK    = 4'd7,
		K_READ_AT      = 4'd8,
		K_FIND         = 4'd9,
		K_CLEAR        = 4'd10
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_RUN  = 2'd1,
		S_DONE = 2'd2
	} state_t;

endpackage

FILE: design/idqe_ifs.sv
// Request and response channel interfaces of the deque engine.
interface idqe_req_if;
	logic                                valid;
	logic                                ready;
	logic [idqe_pkg::KIND_W-1:0]         kind;
	logic signed [idqe_pkg::VALUE_W-1:0] value;
	logic [idqe_pkg::POS_W-1:0]          position;

	modport source (output valid, kind, value, position, input ready);
	modport sink (input valid, kind, value, position, output ready);
endinterface

interface idqe_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [idqe_pkg::VALUE_W-1:0] read_value;
	logic [idqe_pkg::CNT_W-1:0]          found_position;
	logic [idqe_pkg::CNT_W-1:0]          entry_count;
	logic [idqe_pkg::STATUS_W-1:0]       status;

	modport source (output valid, read_value, found_position, entry_count, status, input ready);
	modport sink (input valid, read_value, found_position, entry_count, status, output ready);
endinterface

FILE: design/idqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module idqe_ram #(
	parameter int WIDTH = idqe_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = idqe_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/integer_deque_list_engine.sv
// Deque engine: a ring of signed entries walked by one RAM port under a small sequencer.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | kind, value, position
//  rsp     | out | valid/ready  | read_value, found_position, entry_count, status
//
// Push, pop, clear and every flagged request skip the walk and go from acceptance straight to
// the done state. Reads, remove at, remove value and find walk the entries in the run state,
// one entry per cycle from the single RAM read port; a find that hits stops the walk early.
// The next request is taken once the result has been loaded into the output register.
// Reset clears the state, the ring pointers, the count and the valid flags; the entry RAM needs no clearing pass.
// A result waits in the output register while rsp is stalled; the next request is taken then.
`include "integer_deque_list_engine_defines.svh"

module integer_deque_list_engine #(
	parameter int CAPACITY   = idqe_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = idqe_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	idqe_req_if.sink   req,
	idqe_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam int LW = (CW > idqe_pkg::POS_W) ? CW : idqe_pkg::POS_W;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
			input logic [CW-1:0] idx);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(idx);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		return AW'(sum);
	endfunction

	idqe_pkg::state_t  state_q, state_d;
	idqe_pkg::kind_t   req_kind, kind_q, kind_d;
	idqe_pkg::status_t res_status_q, res_status_d;

	logic [DATA_WIDTH-1:0] req_val, val_q, val_d;
	logic [AW-1:0]         front_q, front_d, front_dec;
	logic [CW-1:0]         count_q, count_d, pos_c;
	logic [CW-1:0]         issue_idx_q, issue_idx_d, end_q, end_d;
	logic [CW-1:0]         wr_idx_q, wr_idx_d, didx_s1;
	logic [CW-1:0]         res_found_q, res_found_d;
	logic [DATA_WIDTH-1:0] res_rd_q, res_rd_d;
	logic                  dv_s1;

	logic                  accept, full, empty, oor, issue, find_hit, run_done, start_run;
	logic                  out_load;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                                out_valid_q;
	logic [idqe_pkg::VALUE_W-1:0]        out_rd_q;
	logic [idqe_pkg::CNT_W-1:0]          out_found_q, out_count_q;
	logic [idqe_pkg::STATUS_W-1:0]       out_status_q;

	assign req_kind  = idqe_pkg::kind_t'(req.kind);
	assign req_val   = DATA_WIDTH'(req.value);
	assign pos_c     = CW'(req.position);
	assign req.ready = (state_q == idqe_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign oor       = (LW'(req.position) >= LW'(count_q));
	assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);

	assign issue     = (state_q == idqe_pkg::S_RUN) && (issue_idx_q < end_q);
	assign find_hit  = dv_s1 && (kind_q == idqe_pkg::K_FIND) && (ram_rdata == val_q);
	assign run_done  = find_hit || (!issue && !dv_s1);
	assign ram_raddr = slot_of(front_q, issue_idx_q);
	assign out_load  = (state_q == idqe_pkg::S_DONE) && (!out_valid_q || rsp.ready);

	idqe_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idqe_pkg::S_IDLE: begin
				if (accept) begin
					state_d = start_run ? idqe_pkg::S_RUN : idqe_pkg::S_DONE;
				end
			end
			idqe_pkg::S_RUN: begin
				if (run_done) begin
					state_d = idqe_pkg::S_DONE;
				end
			end
			idqe_pkg::S_DONE: begin
				if (out_load) begin
					state_d = idqe_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = idqe_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		front_d      = front_q;
		count_d      = count_q;
		kind_d       = kind_q;
		val_d        = val_q;
		issue_idx_d  = issue_idx_q;
		end_d        = end_q;
		wr_idx_d     = wr_idx_q;
		res_rd_d     = res_rd_q;
		res_found_d  = res_found_q;
		res_status_d = res_status_q;
		start_run    = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = slot_of(front_q, wr_idx_q);
		ram_wdata    = ram_rdata;

		if (accept) begin
			kind_d       = req_kind;
			val_d        = req_val;
			res_rd_d     = '0;
			res_found_d  = '0;
			res_status_d = idqe_pkg::STAT_OK;
			issue_idx_d  = '0;
			end_d        = count_q;
			wr_idx_d     = '0;
			case (req_kind) inside
				idqe_pkg::K_PUSH_BACK, idqe_pkg::K_PUSH_FRONT: begin
					if (full) begin
						res_status_d = idqe_pkg::STAT_FULL;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = req_val;
						count_d   = count_q + CW'(1);
						if (req_kind == idqe_pkg::K_PUSH_BACK) begin
							ram_waddr = slot_of(front_q, count_q);
						end else begin
							ram_waddr = front_dec;
							front_d   = front_dec;
						end
					end
				end
				idqe_pkg::K_POP_BACK: begin
					if (!empty) begin
						count_d = count_q - CW'(1);
					end
				end
				idqe_pkg::K_POP_FRONT: begin
					if (!empty) begin
						front_d = slot_of(front_q, CW'(1));
						count_d = count_q - CW'(1);
					end
				end
				idqe_pkg::K_REMOVE_AT: begin
					if (oor) begin
						res_status_d = idqe_pkg::STAT_RANGE;
					end else begin
						start_run   = 1'b1;
						issue_idx_d = pos_c + CW'(1);
						wr_idx_d    = pos_c;
					end
				end
				idqe_pkg::K_REMOVE_VALUE, idqe_pkg::K_FIND: begin
					start_run = 1'b1;
				end
				idqe_pkg::K_READ_FRONT, idqe_pkg::K_READ_BACK: begin
					if (empty) begin
						res_status_d = idqe_pkg::STAT_EMPTY;
					end else begin
						start_run = 1'b1;
						if (req_kind == idqe_pkg::K_READ_FRONT) begin
							issue_idx_d = '0;
							end_d       = CW'(1);
						end else begin
							issue_idx_d = count_q - CW'(1);
							end_d       = count_q;
						end
					end
				end
				idqe_pkg::K_READ_AT: begin
					if (oor) begin
						res_status_d = idqe_pkg::STAT_RANGE;
					end else begin
						start_run   = 1'b1;
						issue_idx_d = pos_c;
						end_d       = pos_c + CW'(1);
					end
				end
				idqe_pkg::K_CLEAR: begin
					count_d = '0;
					front_d = '0;
				end
				default: begin
				end
			endcase
		end

		if (state_q == idqe_pkg::S_RUN) begin
			if (issue) begin
				issue_idx_d = issue_idx_q + CW'(1);
			end
			if (dv_s1) begin
				case (kind_q) inside
					idqe_pkg::K_REMOVE_AT: begin
						ram_we   = 1'b1;
						wr_idx_d = wr_idx_q + CW'(1);
					end
					idqe_pkg::K_REMOVE_VALUE: begin
						if (ram_rdata != val_q) begin
							ram_we   = 1'b1;
							wr_idx_d = wr_idx_q + CW'(1);
						end
					end
					idqe_pkg::K_FIND: begin
						if (find_hit) begin
							res_found_d = didx_s1;
						end
					end
					idqe_pkg::K_READ_FRONT, idqe_pkg::K_READ_BACK, idqe_pkg::K_READ_AT: begin
						res_rd_d = ram_rdata;
					end
					default: begin
					end
				endcase
			end
			if (run_done) begin
				case (kind_q)
					idqe_pkg::K_REMOVE_AT: begin
						count_d = count_q - CW'(1);
					end
					idqe_pkg::K_REMOVE_VALUE: begin
						count_d = wr_idx_q;
					end
					idqe_pkg::K_FIND: begin
						if (!find_hit) begin
							res_found_d = count_q;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (count_d == '0) begin
			front_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idqe_pkg::S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			dv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			dv_s1   <= issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q       <= kind_d;
		val_q        <= val_d;
		issue_idx_q  <= issue_idx_d;
		end_q        <= end_d;
		wr_idx_q     <= wr_idx_d;
		didx_s1      <= issue_idx_q;
		res_rd_q     <= res_rd_d;
		res_found_q  <= res_found_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_rd_q     <= idqe_pkg::VALUE_W'(res_rd_q);
			out_found_q  <= idqe_pkg::CNT_W'(res_found_q);
			out_count_q  <= idqe_pkg::CNT_W'(count_q);
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_value     = out_rd_q;
	assign rsp.found_position = out_found_q;
	assign rsp.entry_count    = out_count_q;
	assign rsp.status         = out_status_q;

	`IDQE_ASSERT_SAME(a_wr_behind_rd, state_q == idqe_pkg::S_RUN, wr_idx_q <= issue_idx_q)
	`IDQE_ASSERT_SAME(a_empty_front, count_q == '0, front_q == '0)
	`IDQE_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_q != idqe_pkg::S_IDLE)

endmodule
